@@ design/chunked_body_decoder_defines.svh @@
// Assertion macros for the checker file of the chunked body decoder.
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CBD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chunked body decoder check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chunked body decoder check failed");

`endif

@@ design/cbd_pkg.sv @@
`timescale 1ns / 1ps
package cbd_pkg;

	// Width of the chunk size counter.
	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [7:0] CHAR_LA   = 8'h61;
	localparam logic [7:0] CHAR_LF_A = 8'h66;
	localparam logic [7:0] CHAR_UA   = 8'h41;
	localparam logic [7:0] CHAR_UF   = 8'h46;

	// Output item kinds.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One result from the parser to the output register.
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] data;
		logic       status;
	} result_t;

	// Hex digit decode: bit 4 set when the byte is a hex digit, low bits hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = c - CHAR_0;
			return {1'b1, d[3:0]};
		end
		if (c >= CHAR_LA && c <= CHAR_LF_A) begin
			d = c - CHAR_LA + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

@@ design/cbd_parser.sv @@
`timescale 1ns / 1ps
module cbd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         body_byte,
	input  logic               end_of_body,
	output cbd_pkg::result_t   result
);

	localparam logic [2:0] PH_SIZE     = 3'd0;
	localparam logic [2:0] PH_EXT      = 3'd1;
	localparam logic [2:0] PH_DATA     = 3'd2;
	localparam logic [2:0] PH_AFTER    = 3'd3;
	localparam logic [2:0] PH_AFTER_CR = 3'd4;
	localparam logic [2:0] PH_DONE     = 3'd5;
	localparam logic [2:0] PH_ERROR    = 3'd6;

	logic [2:0]                   phase_q, phase_n;
	logic [cbd_pkg::SIZE_BITS-1:0] chunk_q, chunk_n;
	logic                         digit_q, digit_n;

	logic [cbd_pkg::SIZE_BITS-1:0] base_chunk, sz_chunk;
	logic                         base_digit, sz_digit;
	logic [2:0]                   sz_phase;
	logic [4:0]                   hex;
	logic                         bad;

	// A size byte seen from a fresh line when it follows data without CRLF.
	always_comb begin
		base_chunk = (phase_q == PH_AFTER) ? '0 : chunk_q;
		base_digit = (phase_q == PH_AFTER) ? 1'b0 : digit_q;
		hex        = cbd_pkg::hex_decode(body_byte);
		sz_chunk   = base_chunk;
		sz_digit   = base_digit;
		sz_phase   = PH_SIZE;
		if (body_byte == cbd_pkg::CHAR_CR || body_byte == cbd_pkg::CHAR_SEMI) begin
			sz_phase = base_digit ? PH_EXT : PH_ERROR;
		end else if (!hex[4] || base_chunk[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
			sz_phase = PH_ERROR;
		end else begin
			sz_chunk = {base_chunk[cbd_pkg::SIZE_BITS-5:0], hex[3:0]};
			sz_digit = 1'b1;
		end
	end

	// Status reported by an end marker in the current phase.
	always_comb begin
		unique case (phase_q)
			PH_SIZE:           bad = digit_q && (chunk_q != '0);
			PH_EXT:            bad = (chunk_q != '0);
			PH_AFTER, PH_DONE: bad = 1'b0;
			default:           bad = 1'b1;
		endcase
	end

	// Next state and result for one word.
	always_comb begin
		phase_n = phase_q;
		chunk_n = chunk_q;
		digit_n = digit_q;
		result  = '0;
		if (end_of_body) begin
			result.valid  = 1'b1;
			result.kind   = cbd_pkg::KIND_STATUS;
			result.status = bad;
			phase_n       = PH_SIZE;
			chunk_n       = '0;
			digit_n       = 1'b0;
		end else begin
			unique case (phase_q)
				PH_SIZE: begin
					phase_n = sz_phase;
					chunk_n = sz_chunk;
					digit_n = sz_digit;
				end
				PH_EXT: begin
					if (body_byte == cbd_pkg::CHAR_LF) begin
						phase_n = (chunk_q == '0) ? PH_DONE : PH_DATA;
					end
				end
				PH_DATA: begin
					result.valid = 1'b1;
					result.kind  = cbd_pkg::KIND_DATA;
					result.data  = body_byte;
					chunk_n      = chunk_q - 1'b1;
					if (chunk_n == '0) begin
						phase_n = PH_AFTER;
					end
				end
				PH_AFTER: begin
					if (body_byte == cbd_pkg::CHAR_CR) begin
						phase_n = PH_AFTER_CR;
					end else begin
						phase_n = sz_phase;
						chunk_n = sz_chunk;
						digit_n = sz_digit;
					end
				end
				PH_AFTER_CR: begin
					if (body_byte == cbd_pkg::CHAR_LF) begin
						phase_n = PH_SIZE;
						chunk_n = '0;
						digit_n = 1'b0;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_n = PH_ERROR;
				end
			endcase
		end
	end

	// Parser state advances only when a word is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			chunk_q <= '0;
			digit_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			chunk_q <= chunk_n;
			digit_q <= digit_n;
		end
	end

endmodule

@@ design/chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// Chunked transfer decoder for an HTTP body.
// Input channel s_axis_*: one body byte per word in tdata, or an end marker
// word with tlast high whose tdata is ignored. Output channel m_axis_*: tuser
// low carries one decoded payload byte, tuser high carries the final status
// of the body (tdata bit 8: 0 well formed, 1 error) and is the last word for
// that body. Size lines, extensions, the CRLF after data and everything past
// the zero chunk produce no output word.
// An accepted word is held in the input register; the parser then updates its
// state and loads the output register. One word is accepted per cycle while the
// output is not stalled; the only loop is the parser state update.
// When the receiver stalls, the output register holds its word; words that
// give no output still advance, and the input register still takes one word
// while a result waits, after which tready drops until the output drains.
// Reset clears the parser to the start of a size line and empties both
// registers. After each end marker the parser returns to that state by itself.
module chunked_body_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] body_byte
	input  logic        s_axis_tlast,  // end_of_body
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] decoded_byte, [8] decode_status, [15:9] zero
	output logic        m_axis_tuser   // item_kind
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             step;
	logic             out_free;
	logic             m_valid_q;
	logic [7:0]       m_byte_q;
	logic             m_status_q;
	logic             m_kind_q;
	cbd_pkg::result_t result;

	cbd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.body_byte   (byte_s1),
		.end_of_body (last_s1),
		.result      (result)
	);

	// A word moves on when it gives no result or the output register can take it.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign step          = valid_s1 && (!result.valid || out_free);
	assign s_axis_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && result.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			m_byte_q   <= result.data;
			m_status_q <= result.status;
			m_kind_q   <= result.kind;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_status_q, m_byte_q};
	assign m_axis_tuser  = m_kind_q;

endmodule

@@ design/cbd_checker.sv @@
`timescale 1ns / 1ps
`include "chunked_body_decoder_defines.svh"
module cbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic out_stall;
	logic data_word;
	logic status_word;

	assign out_stall   = m_axis_tvalid && !m_axis_tready;
	assign data_word   = m_axis_tvalid && (m_axis_tuser == cbd_pkg::KIND_DATA);
	assign status_word = m_axis_tvalid && (m_axis_tuser == cbd_pkg::KIND_STATUS);

	// A stalled output word keeps its contents.
	`CBD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))

	// Data words carry a clear status bit and zero padding.
	`CBD_ASSERT_NOW(a_data_clean, data_word, m_axis_tdata[15:8] == 8'd0)

	// Status words carry a zero byte and zero padding.
	`CBD_ASSERT_NOW(a_status_clean, status_word, {m_axis_tdata[15:9], m_axis_tdata[7:0]} == 15'd0)

	// An idle output register leaves the input side open.
	`CBD_ASSERT_NOW(a_ready_idle, !m_axis_tvalid, s_axis_tready)

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (.*);

@@ tb/sv/chunked_body_decoder_tb.sv @@
`timescale 1ns / 1ps
module chunked_body_decoder_tb;

	// Parser phases of the scoreboard's own decoder.
	typedef enum logic [2:0] {
		SCAN_DIGITS,
		SCAN_EXT,
		SCAN_PAYLOAD,
		SCAN_TAIL,
		SCAN_TAIL_CR,
		SCAN_FINISHED,
		SCAN_BROKEN
	} scan_phase_t;

	// One output word as the decoder should produce it.
	typedef struct {
		logic       kind;
		logic [7:0] payload;
		logic       status;
	} decoded_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] body_byte
	logic        s_axis_tlast;   // end_of_body
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [7:0] decoded_byte, [8] decode_status, [15:9] zero
	logic        m_axis_tuser;   // item_kind

	// Decoder state mirrored by the scoreboard.
	scan_phase_t                   scan_phase;
	logic [cbd_pkg::SIZE_BITS-1:0] chunk_left;
	logic                          have_digit;

	decoded_word_t pending_words[$];

	int src_gap_pct;
	int sink_gap_pct;
	int sink_hold_cycles;
	int mismatches;
	int bodies_sent;
	int live_items;
	int payload_words_seen;
	int clean_status_seen;
	int failed_status_seen;

	chunked_body_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Bit 4 flags a hex digit; the low nibble is its value.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c inside {[cbd_pkg::CHAR_0:cbd_pkg::CHAR_9]}) return {1'b1, c[3:0]};
		if (c inside {[cbd_pkg::CHAR_LA:cbd_pkg::CHAR_LF_A],
			[cbd_pkg::CHAR_UA:cbd_pkg::CHAR_UF]}) return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	function automatic void restart_size_line();
		scan_phase = SCAN_DIGITS;
		chunk_left = '0;
		have_digit = 1'b0;
	endfunction

	// One byte of a size line; digits past the counter width break the body.
	function automatic void take_size_char(input logic [7:0] c);
		logic [4:0] nib;
		nib = nibble_of(c);
		if (c == cbd_pkg::CHAR_CR || c == cbd_pkg::CHAR_SEMI) begin
			scan_phase = have_digit ? SCAN_EXT : SCAN_BROKEN;
		end else if (!nib[4] || chunk_left[cbd_pkg::SIZE_BITS-1 -: 4] != 0) begin
			scan_phase = SCAN_BROKEN;
		end else begin
			chunk_left = {chunk_left[cbd_pkg::SIZE_BITS-5:0], nib[3:0]};
			have_digit = 1'b1;
		end
	endfunction

	// Advance the mirrored decoder by one accepted word and queue its result.
	function automatic void decode_step(input logic [7:0] c, input logic eob);
		decoded_word_t w;
		logic bad;
		if (eob || (scan_phase != SCAN_FINISHED && scan_phase != SCAN_BROKEN)) live_items++;
		if (eob) begin
			case (scan_phase)
				SCAN_DIGITS:              bad = have_digit && chunk_left != 0;
				SCAN_EXT:                 bad = chunk_left != 0;
				SCAN_TAIL, SCAN_FINISHED: bad = 1'b0;
				default:                  bad = 1'b1;
			endcase
			w.kind    = cbd_pkg::KIND_STATUS;
			w.payload = 8'd0;
			w.status  = bad;
			pending_words.push_back(w);
			restart_size_line();
			return;
		end
		case (scan_phase)
			SCAN_DIGITS: take_size_char(c);
			SCAN_EXT: begin
				if (c == cbd_pkg::CHAR_LF)
					scan_phase = (chunk_left == 0) ? SCAN_FINISHED : SCAN_PAYLOAD;
			end
			SCAN_PAYLOAD: begin
				w.kind    = cbd_pkg::KIND_DATA;
				w.payload = c;
				w.status  = 1'b0;
				pending_words.push_back(w);
				chunk_left = chunk_left - 1'b1;
				if (chunk_left == 0) scan_phase = SCAN_TAIL;
			end
			SCAN_TAIL: begin
				if (c == cbd_pkg::CHAR_CR) begin
					scan_phase = SCAN_TAIL_CR;
				end else begin
					restart_size_line();
					take_size_char(c);
				end
			end
			SCAN_TAIL_CR: begin
				if (c == cbd_pkg::CHAR_LF) restart_size_line();
				else scan_phase = SCAN_BROKEN;
			end
			SCAN_FINISHED: ;
			default: scan_phase = SCAN_BROKEN;
		endcase
	endfunction

	// Offer one word, with random gaps before it, and wait for the handshake.
	task automatic send_word(input logic [7:0] c, input logic eob);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eob;
		do @(posedge clk); while (!s_axis_tready);
		decode_step(c, eob);
	endtask

	// A whole body followed by its end marker, whose data byte is junk.
	task automatic send_body(input logic [7:0] txt[$]);
		foreach (txt[i]) send_word(txt[i], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
		bodies_sent++;
	endtask

	// Stop offering words and wait until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_text(ref logic [7:0] txt[$], input string s);
		for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
	endfunction

	function automatic void add_crlf(ref logic [7:0] txt[$]);
		txt.push_back(cbd_pkg::CHAR_CR);
		txt.push_back(cbd_pkg::CHAR_LF);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return cbd_pkg::CHAR_0 + nib;
		return ($urandom_range(0, 1) ? cbd_pkg::CHAR_LA : cbd_pkg::CHAR_UA) + nib - 8'd10;
	endfunction

	function automatic logic [7:0] any_but_lf();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == cbd_pkg::CHAR_LF);
		return c;
	endfunction

	// Size line in mixed case, sometimes with leading zeros or an extension.
	function automatic void add_size_line(ref logic [7:0] txt[$],
		input logic [cbd_pkg::SIZE_BITS-1:0] size);
		int top;
		top = 0;
		for (int i = 0; i < cbd_pkg::SIZE_BITS / 4; i++) if (size[4*i +: 4] != 0) top = i;
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) txt.push_back(cbd_pkg::CHAR_0);
		for (int i = top; i >= 0; i--) txt.push_back(hex_char(size[4*i +: 4]));
		case ($urandom_range(0, 5))
			0: begin
				txt.push_back(cbd_pkg::CHAR_SEMI);
				repeat ($urandom_range(0, 4)) txt.push_back(any_but_lf());
				add_crlf(txt);
			end
			1: begin
				txt.push_back(cbd_pkg::CHAR_SEMI);
				txt.push_back(cbd_pkg::CHAR_LF);
			end
			default: add_crlf(txt);
		endcase
	endfunction

	// Mostly well-formed bodies with random content; the rest noise or damaged.
	function automatic void build_random_body(ref logic [7:0] txt[$]);
		int pick;
		int cut;
		logic [cbd_pkg::SIZE_BITS-1:0] size;
		txt.delete();
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(0, 10)) txt.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3)) begin
			size = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			add_size_line(txt, size);
			repeat (size) txt.push_back(8'($urandom_range(0, 255)));
			// Now and then the next size line follows the data with no CRLF.
			if ($urandom_range(0, 9) != 0) add_crlf(txt);
		end
		add_size_line(txt, '0);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 6)) txt.push_back(any_but_lf());
			add_crlf(txt);
		end
		add_crlf(txt);
		if (pick < 80) return;
		case (pick % 5)
			0: begin
				cut = $urandom_range(1, txt.size());
				while (txt.size() > cut) void'(txt.pop_back());
			end
			1: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
			2: txt[$urandom_range(0, txt.size() - 1)] = cbd_pkg::CHAR_CR;
			3: begin
				// A chunk far longer than the body that carries it.
				txt.delete();
				size = $urandom;
				size[cbd_pkg::SIZE_BITS-1 -: 4] = 4'($urandom_range(1, 15));
				add_size_line(txt, size);
				repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				// More significant digits than the size counter holds.
				txt.delete();
				txt.push_back(hex_char(4'($urandom_range(1, 15))));
				repeat ($urandom_range(cbd_pkg::SIZE_BITS / 4, cbd_pkg::SIZE_BITS / 4 + 3))
					txt.push_back(hex_char(4'($urandom_range(0, 15))));
				add_crlf(txt);
				repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	// One body for each of several error rules, plus extreme byte values and the end marker paths.
	task automatic test_directed_cases();
		logic [7:0] txt[$];
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		// Short chunk behind an empty extension, carrying the top byte value.
		txt.delete();
		add_text(txt, "2;");
		txt.push_back(cbd_pkg::CHAR_LF);
		txt.push_back(8'hFF);
		send_body(txt);
		// Non-hex byte in the size.
		txt.delete();
		add_text(txt, "G");
		send_body(txt);
		// Size line with no digits.
		txt.delete();
		add_text(txt, ";");
		send_body(txt);
		// Size that overflows the counter.
		txt.delete();
		add_text(txt, "FFFFFFFFF");
		send_body(txt);
		// Lone CR after the data, carrying the bottom byte value.
		txt.delete();
		add_text(txt, "1");
		add_crlf(txt);
		txt.push_back(8'h00);
		txt.push_back(cbd_pkg::CHAR_CR);
		add_text(txt, "Z");
		send_body(txt);
		// Zero chunk, then a byte that must be ignored.
		txt.delete();
		add_text(txt, "0;");
		txt.push_back(cbd_pkg::CHAR_LF);
		add_text(txt, "x");
		send_body(txt);
		wait_drained();
	endtask

	// Receiver holds off long enough for the decoder to stall its input.
	task automatic test_output_backpressure();
		logic [7:0] txt[$];
		src_gap_pct      = 0;
		sink_gap_pct     = 0;
		sink_hold_cycles = 80;
		txt.delete();
		add_size_line(txt, 40);
		repeat (40) txt.push_back(8'($urandom_range(0, 255)));
		add_crlf(txt);
		add_size_line(txt, '0);
		add_crlf(txt);
		send_body(txt);
		wait_drained();
	endtask

	// Sender goes quiet until every result is out, then starts a new body.
	task automatic test_pause_until_drained();
		logic [7:0] txt[$];
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		repeat (3) begin
			build_random_body(txt);
			send_body(txt);
			wait_drained();
		end
	endtask

	task automatic test_random_bodies(input int src_gap, input int sink_gap, input int item_goal);
		logic [7:0] txt[$];
		int start;
		src_gap_pct  = src_gap;
		sink_gap_pct = sink_gap;
		start = live_items;
		while (live_items - start < item_goal) begin
			build_random_body(txt);
			send_body(txt);
		end
		wait_drained();
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_cycles--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
		end
	end

	// Compare every accepted output word against the oldest expectation.
	always @(posedge clk) begin : check_output
		decoded_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected output word: kind %0d, tdata %0h", m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (m_axis_tuser !== want.kind) begin
					$error("item_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[7:0] !== want.payload) begin
					$error("decoded_byte: expected %0h, actual %0h", want.payload,
						m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[8] !== want.status) begin
					$error("decode_status: expected %0d, actual %0d", want.status,
						m_axis_tdata[8]);
					mismatches++;
				end
				if (m_axis_tdata[15:9] !== 7'd0) begin
					$error("tdata pad: expected 0, actual %0h", m_axis_tdata[15:9]);
					mismatches++;
				end
				if (want.kind == cbd_pkg::KIND_DATA) payload_words_seen++;
				else if (want.status) failed_status_seen++;
				else clean_status_seen++;
			end
		end
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		s_axis_tvalid      = 1'b0;
		s_axis_tdata       = 8'd0;
		s_axis_tlast       = 1'b0;
		m_axis_tready      = 1'b0;
		src_gap_pct        = 0;
		sink_gap_pct       = 0;
		sink_hold_cycles   = 0;
		mismatches         = 0;
		bodies_sent        = 0;
		live_items         = 0;
		payload_words_seen = 0;
		clean_status_seen  = 0;
		failed_status_seen = 0;
		restart_size_line();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_output_backpressure();
		test_pause_until_drained();
		test_random_bodies(14, 60, 430);
		test_random_bodies(60, 14, 430);
		test_random_bodies(0, 0, 440);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d expected words never arrived", pending_words.size());
			mismatches++;
		end

		$display("Decoded %0d bodies (%0d live input words): %0d payload words checked,",
			bodies_sent, live_items, payload_words_seen);
		$display("%0d bodies ended clean and %0d ended in error.", clean_status_seen,
			failed_status_seen);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
